/* hw/rtl/text_token_splitter_assert.svh */
// assertion helpers used by tts_outbuf
`ifndef TEXT_TOKEN_SPLITTER_ASSERT_SVH
`define TEXT_TOKEN_SPLITTER_ASSERT_SVH

// same-cycle implication
`define TTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tts assertion failed");

// next-cycle implication
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tts assertion failed");

`endif

/* hw/rtl/tts_pkg.sv */
`timescale 1ns / 1ps

package tts_pkg;

   // result kinds
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // scan modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_TOKEN   = 2'd1;
   localparam logic [1:0] MODE_QUOTE   = 2'd2;
   localparam logic [1:0] MODE_COMMENT = 2'd3;

   // token classes
   localparam logic [2:0] CLS_WORD   = 3'd0;
   localparam logic [2:0] CLS_NUMBER = 3'd1;
   localparam logic [2:0] CLS_PUNCT  = 3'd2;
   localparam logic [2:0] CLS_QUOTED = 3'd3;
   localparam logic [2:0] CLS_OTHER  = 3'd4;

   // characters
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_LOWER_X    = 8'h78;
   localparam logic [7:0] CH_UPPER_X    = 8'h58;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_DEL        = 8'h7F;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_buffer;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [7:0]  out_symbol;
      logic        first_of_token;
      logic [2:0]  token_class;
      logic [15:0] token_total;
      logic        last_of_run;
   } rsp_item_type;

   // results of one input item, oldest in entry 0
   typedef struct packed {
      logic [2:0]             count;
      rsp_item_type [3:0]     items;
   } rsp_group_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] cls;
      logic       held;
      logic       chars;
   } scan_state_type;

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_xdigit(logic [7:0] c);
      return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic is_sep(logic [7:0] c);
      return c <= CH_SPACE || c == CH_DEL;
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return c > CH_SPACE && c < CH_DEL && !is_alpha(c) && !is_digit(c);
   endfunction

   function automatic logic accepts(logic [2:0] cls, logic [7:0] c);
      logic r;
      r = 1'b1;
      if (cls == CLS_WORD) begin
         r = is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE;
      end else if (cls == CLS_NUMBER) begin
         r = is_xdigit(c) || c == CH_DOT || c == CH_LOWER_X || c == CH_UPPER_X;
      end else if (cls == CLS_PUNCT) begin
         r = is_punct(c);
      end
      return r;
   endfunction

endpackage

/* hw/rtl/text_token_splitter.sv */
`timescale 1ns / 1ps

// text_token_splitter: splits a byte stream into word, number, punctuation,
// quoted and other-byte tokens; whitespace is skipped, // comments dropped.
// req channel: one character item (symbol, end_of_buffer) per handshake,
// taken on a rising edge with req_valid high and req_stall low.
// rsp channel: token characters, end markers and one done item per buffer,
// handed over on rsp_valid high and rsp_stall low; last_of_run flags the
// final result of each input item.
// path: a taken item waits in the input register, is scanned as it moves
// into the output buffer, and its results are handed over from there.
// throughput: one item per cycle while items give at most one result and
// rsp_stall is low; an item with more results holds req_stall while the
// single result read port of the output buffer drains them.
// reset (synchronous, active high) empties both stages and returns the
// scanner to idle with a zero token count.
// a stalled receiver freezes the output buffer; the input register still
// takes one more item, then req_stall rises.
module text_token_splitter import tts_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   // input register
   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff;

   logic          can_load;
   logic          advance;
   logic          req_take;
   rsp_group_type scan_group;

   always_comb begin
      // the held item moves into the scanner once the output buffer frees up
      advance   = in_valid_ff && can_load;
      req_stall = in_valid_ff && !can_load;
      req_take  = req_valid && !req_stall;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   // scan state and the result list of the item in the input register
   tts_scan #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .in_item   (in_item_ff),
      .out_group (scan_group)
   );

   // result register, drained one item per cycle while rsp_stall is low
   tts_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .in_group  (scan_group),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .can_load  (can_load)
   );

endmodule

/* hw/rtl/tts_scan.sv */
`timescale 1ns / 1ps

module tts_scan import tts_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step_en,
   input  req_item_type  in_item,
   output rsp_group_type out_group
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      scan_state_type          st;
      logic [COUNT_BITS-1:0]   cnt;
      logic [2:0]              n;
      rsp_item_type [4:0]      items;
   } ctx_type;

   scan_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   function automatic ctx_type push_item(ctx_type c, logic [1:0] kind, logic [7:0] sym,
                                         logic first, logic [2:0] cls);
      ctx_type     r;
      logic [31:0] wide;
      r    = c;
      wide = 32'(c.cnt);
      if (c.n < 3'd5) begin
         r.items[c.n].item_kind      = kind;
         r.items[c.n].out_symbol     = sym;
         r.items[c.n].first_of_token = first;
         r.items[c.n].token_class    = cls;
         r.items[c.n].token_total    = wide[15:0];
         r.items[c.n].last_of_run    = 1'b0;
         r.n = c.n + 3'd1;
      end
      return r;
   endfunction

   function automatic ctx_type end_token(ctx_type c);
      ctx_type r;
      logic    empty;
      r     = c;
      empty = (c.st.mode == MODE_QUOTE) && !c.st.chars;
      if (c.cnt != COUNT_MAX) begin
         r.cnt = c.cnt + 1'b1;
      end
      r = push_item(r, KIND_END, CH_NUL, empty, c.st.cls);
      r.st.mode  = MODE_IDLE;
      r.st.chars = 1'b0;
      return r;
   endfunction

   function automatic ctx_type start_token(ctx_type c, logic [7:0] ch);
      ctx_type r;
      r = c;
      if (ch == CH_QUOTE) begin
         r.st.mode  = MODE_QUOTE;
         r.st.cls   = CLS_QUOTED;
         r.st.chars = 1'b0;
      end else begin
         if (is_alpha(ch)) begin
            r.st.cls = CLS_WORD;
         end else if (is_digit(ch)) begin
            r.st.cls = CLS_NUMBER;
         end else if (is_punct(ch)) begin
            r.st.cls = CLS_PUNCT;
         end else begin
            r.st.cls = CLS_OTHER;
         end
         r.st.mode = MODE_TOKEN;
         r = push_item(r, KIND_CHAR, ch, 1'b1, r.st.cls);
      end
      return r;
   endfunction

   function automatic ctx_type handle_char(ctx_type c, logic [7:0] ch, logic may_hold);
      ctx_type r;
      logic    fall;
      r    = c;
      fall = 1'b0;
      if (c.st.mode == MODE_COMMENT) begin
         if (ch == CH_NEWLINE) begin
            r.st.mode = MODE_IDLE;
         end
      end else if (c.st.mode == MODE_QUOTE) begin
         if (ch == CH_QUOTE) begin
            r = end_token(r);
         end else begin
            r = push_item(r, KIND_CHAR, ch, !c.st.chars, CLS_QUOTED);
            r.st.chars = 1'b1;
         end
      end else begin
         fall = 1'b1;
         if (c.st.mode == MODE_TOKEN) begin
            fall = 1'b0;
            if (ch == CH_SLASH && may_hold) begin
               // words and numbers never take a slash, so they close now
               if (c.st.cls == CLS_WORD || c.st.cls == CLS_NUMBER) begin
                  r = end_token(r);
               end
               r.st.held = 1'b1;
            end else if (is_sep(ch)) begin
               r = end_token(r);
            end else if (accepts(c.st.cls, ch)) begin
               r = push_item(r, KIND_CHAR, ch, 1'b0, c.st.cls);
            end else begin
               r    = end_token(r);
               fall = 1'b1;
            end
         end
         if (fall) begin
            if (ch == CH_SLASH && may_hold) begin
               r.st.held = 1'b1;
            end else if (!is_sep(ch)) begin
               r = start_token(r, ch);
            end
         end
      end
      return r;
   endfunction

   always_comb begin
      ctx_type ctx;
      logic    eob;
      ctx       = '0;
      ctx.st    = state_ff;
      ctx.cnt   = cnt_ff;
      eob       = (in_item.symbol == CH_NUL) || in_item.end_of_buffer;
      if (in_item.symbol != CH_NUL) begin
         if (ctx.st.held) begin
            ctx.st.held = 1'b0;
            if (in_item.symbol == CH_SLASH) begin
               // comment start closes any open token
               if (ctx.st.mode == MODE_TOKEN) begin
                  ctx = end_token(ctx);
               end
               ctx.st.mode = MODE_COMMENT;
            end else begin
               ctx = handle_char(ctx, CH_SLASH, 1'b0);
               ctx = handle_char(ctx, in_item.symbol, 1'b1);
            end
         end else begin
            ctx = handle_char(ctx, in_item.symbol, 1'b1);
         end
      end
      if (eob) begin
         if (ctx.st.held) begin
            ctx.st.held = 1'b0;
            ctx = handle_char(ctx, CH_SLASH, 1'b0);
         end
         if (ctx.st.mode == MODE_TOKEN || ctx.st.mode == MODE_QUOTE) begin
            ctx = end_token(ctx);
         end
         ctx = push_item(ctx, KIND_DONE, CH_NUL, 1'b0, CLS_WORD);
         ctx.st.mode  = MODE_IDLE;
         ctx.st.cls   = CLS_WORD;
         ctx.st.chars = 1'b0;
         ctx.cnt      = '0;
      end
      // five results: the end marker before the done item is dropped
      if (ctx.n == 3'd5) begin
         ctx.items[3] = ctx.items[4];
         ctx.n        = 3'd4;
      end
      for (int k = 0; k < 4; k++) begin
         ctx.items[k].last_of_run = (3'(k) == ctx.n - 3'd1);
      end
      out_group.count = ctx.n;
      out_group.items = ctx.items[3:0];
      state_in        = ctx.st;
      cnt_in          = ctx.cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* hw/rtl/tts_outbuf.sv */
`timescale 1ns / 1ps

`include "text_token_splitter_assert.svh"

module tts_outbuf import tts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_group_type in_group,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_item_type  rsp_item,
   output logic          can_load
);

   rsp_item_type [3:0] items_ff;
   logic [2:0]         left_ff, left_in;
   logic [1:0]         rd_ff, rd_in;
   logic               take;

   always_comb begin
      rsp_valid = (left_ff != 3'd0);
      rsp_item  = items_ff[rd_ff];
      take      = rsp_valid && !rsp_stall;
      // empty, or the last waiting item leaves this cycle
      can_load  = (left_ff == 3'd0) || (left_ff == 3'd1 && take);
      left_in   = left_ff;
      rd_in     = rd_ff;
      if (load) begin
         left_in = in_group.count;
         rd_in   = 2'd0;
      end else if (take) begin
         left_in = left_ff - 3'd1;
         rd_in   = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 3'd0;
         rd_ff   <= 2'd0;
      end else begin
         left_ff <= left_in;
         rd_ff   <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= in_group.items;
      end
   end

   `TTS_ASSERT_NOW(a_load_safe, clock, reset, load, left_ff == 3'd0 || (left_ff == 3'd1 && take))
   `TTS_ASSERT_NOW(a_last_flag, clock, reset, rsp_valid, rsp_item.last_of_run == (left_ff == 3'd1))
   `TTS_ASSERT_NOW(a_done_last, clock, reset, rsp_valid && rsp_item.item_kind == KIND_DONE, rsp_item.last_of_run)
   `TTS_ASSERT_NEXT(a_load_count, clock, reset, load, left_ff == $past(in_group.count))

endmodule
